/* src/kuf_pkg.sv */
// Package for the union-find edge acceptor: sizes, constants and the
// payload structs of the input and result channels. No dependencies.
package kuf_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int NCNT_BITS   = 11;
  localparam int EDGE_W_BITS = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int COST_BITS   = 32;

  localparam logic [NCNT_BITS-1:0] NCNT_MAX   = NCNT_BITS'(MAX_NODES);
  localparam logic [NCNT_BITS-1:0] NCNT_MIN   = NCNT_BITS'(1);
  localparam logic [NODE_BITS-1:0] NODE_LAST  = NODE_BITS'(MAX_NODES - 1);
  localparam logic [COST_BITS-1:0] COST_SAT   = {COST_BITS{1'b1}};

  typedef struct packed {
    logic [NODE_BITS-1:0]   node_a;
    logic [NODE_BITS-1:0]   node_b;
    logic [EDGE_W_BITS-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 already_joined;
    logic [NODE_BITS-1:0] tree_edge_count;
    logic [COST_BITS-1:0] tree_cost;
    logic                 tree_complete;
  } out_item_t;

endpackage

/* src/kruskal_union_find_edge_acceptor_core.sv */
// Kruskal tree-edge acceptor: union-find forest with path compression,
// running tree cost and edge count. Depends on kuf_pkg.
//
//  Channel  | Ports                           | Handshake
//  ---------+---------------------------------+-------------------------------
//  input    | start, busy, in_data            | beat taken when start && !busy
//  result   | out_valid, out_data             | one-cycle strobe, no backpressure
//  config   | cfg_valid, cfg_ready, cfg_data  | beat taken when valid && ready
//
// An edge that is ignored (tree complete or endpoint out of range) returns its
// result in the next cycle, and busy stays low. Any other edge walks the chain
// from each endpoint to its root and rewrites the walked nodes to point at the
// root (path compression), with busy high; the single read port of the parent
// memory paces this, one parent read per cycle.
// After reset and after every config write the parent memory is swept to
// identity, every entry, one entry a cycle, with busy high. Results cannot be
// stalled; the receiver must take each strobe.
module kruskal_union_find_edge_acceptor_core
  import kuf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [NCNT_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_SWITCH,
    S_LINK
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NODE_BITS-1:0]   clr_r, clr_nxt;
  logic [NODE_BITS-1:0]   node_a_r, node_a_nxt;
  logic [NODE_BITS-1:0]   node_b_r, node_b_nxt;
  logic [WEIGHT_BITS-1:0] weight_r, weight_nxt;
  logic                   side_r, side_nxt;
  logic [NODE_BITS-1:0]   cur_r, cur_nxt;
  logic [NODE_BITS-1:0]   root_r, root_nxt;
  logic [NODE_BITS-1:0]   ra_r, ra_nxt;
  logic [COST_BITS-1:0]   cost_r, cost_nxt;
  logic [NODE_BITS-1:0]   count_r, count_nxt;
  logic [NCNT_BITS-1:0]   ncnt_r, ncnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // Parent memory: one write and one registered read per cycle.
  logic [NODE_BITS-1:0]   parent_mem [MAX_NODES];
  logic [NODE_BITS-1:0]   rdata_r;
  logic [NODE_BITS-1:0]   mem_raddr;
  logic                   mem_we;
  logic [NODE_BITS-1:0]   mem_waddr;
  logic [NODE_BITS-1:0]   mem_wdata;

  logic [NODE_BITS-1:0]   side_node;
  logic [NCNT_BITS-1:0]   ncnt_m1;
  logic [COST_BITS:0]     cost_sum;
  logic                   edge_live;
  logic [NODE_BITS-1:0]   count_inc;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign side_node = side_r ? node_b_r : node_a_r;
  assign ncnt_m1   = ncnt_r - NCNT_MIN;
  assign cost_sum  = {1'b0, cost_r} + (COST_BITS + 1)'(weight_r);
  assign count_inc = count_r + NODE_BITS'(1);
  // Edge takes part only when the tree is open and both ends are in range.
  assign edge_live = ({1'b0, count_r} < ncnt_m1)
                  && (NCNT_BITS'(in_data.node_a) < ncnt_r)
                  && (NCNT_BITS'(in_data.node_b) < ncnt_r);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_a_nxt    = node_a_r;
    node_b_nxt    = node_b_r;
    weight_nxt    = weight_r;
    side_nxt      = side_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    ra_nxt        = ra_r;
    cost_nxt      = cost_r;
    count_nxt     = count_r;
    ncnt_nxt      = ncnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_raddr     = cur_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    mem_wdata     = root_r;

    case (state_r)
      S_CLEAR: begin
        // Sweep the forest back to identity.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = clr_r;
        clr_nxt   = clr_r + NODE_BITS'(1);
        if (clr_r == NODE_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = in_data.node_a;
        if (start) begin
          node_a_nxt = in_data.node_a;
          node_b_nxt = in_data.node_b;
          weight_nxt = in_data.edge_weight[WEIGHT_BITS-1:0];
          if (edge_live) begin
            side_nxt  = 1'b0;
            root_nxt  = in_data.node_a;
            state_nxt = S_FIND;
          end else begin
            // Drop the edge: report state unchanged.
            out_valid_nxt                = 1'b1;
            out_data_nxt.accepted        = 1'b0;
            out_data_nxt.already_joined  = 1'b0;
            out_data_nxt.tree_edge_count = count_r;
            out_data_nxt.tree_cost       = cost_r;
            out_data_nxt.tree_complete   = ({1'b0, count_r} >= ncnt_m1);
          end
        end
      end
      S_FIND: begin
        // rdata_r holds the parent of root_r.
        if (rdata_r == root_r) begin
          if (side_node == root_r) begin
            if (side_r) begin
              state_nxt = S_LINK;
            end else begin
              ra_nxt    = root_r;
              side_nxt  = 1'b1;
              root_nxt  = node_b_r;
              state_nxt = S_SWITCH;
            end
          end else begin
            mem_raddr = side_node;
            cur_nxt   = side_node;
            state_nxt = S_COMP;
          end
        end else begin
          root_nxt  = rdata_r;
          mem_raddr = rdata_r;
        end
      end
      S_COMP: begin
        // Point cur at the root, advance to its old parent.
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = root_r;
        cur_nxt   = rdata_r;
        mem_raddr = rdata_r;
        if (rdata_r == root_r) begin
          if (side_r) begin
            state_nxt = S_LINK;
          end else begin
            ra_nxt    = root_r;
            side_nxt  = 1'b1;
            root_nxt  = node_b_r;
            state_nxt = S_SWITCH;
          end
        end
      end
      S_SWITCH: begin
        mem_raddr = node_b_r;
        state_nxt = S_FIND;
      end
      S_LINK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (ra_r == root_r) begin
          out_data_nxt.accepted        = 1'b0;
          out_data_nxt.already_joined  = 1'b1;
          out_data_nxt.tree_edge_count = count_r;
          out_data_nxt.tree_cost       = cost_r;
          out_data_nxt.tree_complete   = ({1'b0, count_r} >= ncnt_m1);
        end else begin
          // Hang root of node_a under root of node_b.
          mem_we    = 1'b1;
          mem_waddr = ra_r;
          mem_wdata = root_r;
          cost_nxt  = cost_sum[COST_BITS] ? COST_SAT : cost_sum[COST_BITS-1:0];
          count_nxt = count_inc;
          out_data_nxt.accepted        = 1'b1;
          out_data_nxt.already_joined  = 1'b0;
          out_data_nxt.tree_edge_count = count_inc;
          out_data_nxt.tree_cost       = cost_nxt;
          out_data_nxt.tree_complete   = ({1'b0, count_inc} >= ncnt_m1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A config beat restarts the forest.
    if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        ncnt_nxt = NCNT_MIN;
      end else if (cfg_data > NCNT_MAX) begin
        ncnt_nxt = NCNT_MAX;
      end else begin
        ncnt_nxt = cfg_data;
      end
      cost_nxt  = '0;
      count_nxt = '0;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cost_r      <= '0;
      count_r     <= '0;
      ncnt_r      <= NCNT_MAX;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      side_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cost_r      <= cost_nxt;
      count_r     <= count_nxt;
      ncnt_r      <= ncnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      side_r      <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_a_r   <= node_a_nxt;
    node_b_r   <= node_b_nxt;
    weight_r   <= weight_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    ra_r       <= ra_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      parent_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= parent_mem[mem_raddr];
  end

  // A result is never both a join and a rejection.
  a_acc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.accepted && out_data.already_joined))
    else $error("accepted and already_joined both set");

  // An accepted edge bumps the count by exactly one.
  a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accepted) |->
      (count_r == $past(count_r) + NODE_BITS'(1)))
    else $error("accepted edge did not advance count");

  // The count never reaches the node count.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} < ncnt_r))
    else $error("edge count out of bounds");

  // Busy is high in the FIND, COMP and LINK states of a walk.
  a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND || state_r == S_COMP || state_r == S_LINK) |-> busy)
    else $error("busy low during a walk");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for kruskal_union_find_edge_acceptor_core.
// Checks every result beat against a built-in union-find predictor across many
// node-count settings. Depends on kuf_pkg and the core RTL.
module tb_top;
  import kuf_pkg::*;

  typedef struct {
    bit       drain;  // hold the sender until every pending result is back
    in_item_t item;
  } edge_feed_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [NCNT_BITS-1:0] cfg_data  = '0;

  kruskal_union_find_edge_acceptor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state: its own forest, cost and edge count.
  logic [NODE_BITS-1:0] parent_tbl [MAX_NODES];
  logic [COST_BITS-1:0] running_cost;
  logic [NODE_BITS-1:0] joined_edges;
  int                   forest_nodes;

  edge_feed_t edge_feed_q[$];
  out_item_t  pending_tree_results[$];

  int    sender_idle_pct = 0;
  int    plan_nodes      = MAX_NODES;  // node count the stimulus is built for
  int    fail_count      = 0;
  int    beats_checked   = 0;
  int    live_edges      = 0;          // edges that reached the forest
  int    queued_items    = 0;
  int    trees_closed    = 0;
  int    count_writes    = 0;
  longint run_budget     = 20000;
  longint cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clamp the written node count and start a fresh forest.
  function automatic void reset_forest(input int raw);
    forest_nodes = (raw == 0) ? 1 : (raw > MAX_NODES) ? MAX_NODES : raw;
    for (int i = 0; i < MAX_NODES; i++) parent_tbl[i] = NODE_BITS'(i);
    running_cost = '0;
    joined_edges = '0;
  endfunction

  // Walk to the root, then hang every node on the walked path directly on it.
  function automatic logic [NODE_BITS-1:0] find_root(input logic [NODE_BITS-1:0] x);
    logic [NODE_BITS-1:0] root;
    logic [NODE_BITS-1:0] cur;
    logic [NODE_BITS-1:0] up;
    int steps;
    root  = x;
    steps = 0;
    while (steps < MAX_NODES && parent_tbl[root] != root) begin
      root = parent_tbl[root];
      steps++;
    end
    cur   = x;
    steps = 0;
    while (cur != root && steps < MAX_NODES) begin
      up             = parent_tbl[cur];
      parent_tbl[cur] = root;
      cur            = up;
      steps++;
    end
    return root;
  endfunction

  // Apply one edge to the predicted forest and return the result it produces.
  function automatic out_item_t accept_edge(input in_item_t e);
    out_item_t r;
    logic [NODE_BITS-1:0] ra;
    logic [NODE_BITS-1:0] rb;
    logic [COST_BITS-1:0] wt;
    r  = '0;
    wt = COST_BITS'(e.edge_weight[WEIGHT_BITS-1:0]);
    // Complete tree or out-of-range endpoint: ignore, no find, no compression.
    if (int'(joined_edges) < forest_nodes - 1 && int'(e.node_a) < forest_nodes &&
        int'(e.node_b) < forest_nodes) begin
      live_edges++;
      ra = find_root(e.node_a);
      rb = find_root(e.node_b);
      if (ra == rb) begin
        r.already_joined = 1'b1;
      end else begin
        parent_tbl[ra] = rb;
        running_cost   = (running_cost > COST_SAT - wt) ? COST_SAT : running_cost + wt;
        joined_edges++;
        r.accepted = 1'b1;
        if (int'(joined_edges) == forest_nodes - 1) trees_closed++;
      end
    end
    r.tree_edge_count = joined_edges;
    r.tree_cost       = running_cost;
    r.tree_complete   = (int'(joined_edges) >= forest_nodes - 1);
    return r;
  endfunction

  // Driver: take a beat when start && !busy, predict it, then pick the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_tree_results.insert(pending_tree_results.size(), accept_edge(in_data));
        void'(edge_feed_q.pop_front());
      end
      // Hold start and data while the core is busy with an offered beat.
      if (!(start && busy)) begin
        if (edge_feed_q.size() != 0 && edge_feed_q[0].drain) begin
          start <= 1'b0;
          if (pending_tree_results.size() == 0) void'(edge_feed_q.pop_front());
        end else if (edge_feed_q.size() != 0 &&
                     $urandom_range(99) >= sender_idle_pct) begin
          start   <= 1'b1;
          in_data <= edge_feed_q[0].item;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest pending prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_tree_results.size() == 0) begin
        $error("result beat with no edge pending: %p", out_data);
        fail_count++;
      end else begin
        want = pending_tree_results.pop_front();
        beats_checked++;
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          fail_count++;
        end
        if (out_data.already_joined !== want.already_joined) begin
          $error("already_joined: expected %0d, got %0d",
                 want.already_joined, out_data.already_joined);
          fail_count++;
        end
        if (out_data.tree_edge_count !== want.tree_edge_count) begin
          $error("tree_edge_count: expected %0d, got %0d",
                 want.tree_edge_count, out_data.tree_edge_count);
          fail_count++;
        end
        if (out_data.tree_cost !== want.tree_cost) begin
          $error("tree_cost: expected %0d, got %0d", want.tree_cost, out_data.tree_cost);
          fail_count++;
        end
        if (out_data.tree_complete !== want.tree_complete) begin
          $error("tree_complete: expected %0d, got %0d",
                 want.tree_complete, out_data.tree_complete);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: the budget grows with every queued edge and every node-count write.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > run_budget) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Queue one edge; budget covers two full-length walks plus a long gap.
  function automatic void queue_edge(input int a, input int b, input int w);
    edge_feed_t s;
    s.drain            = 1'b0;
    s.item.node_a      = NODE_BITS'(a);
    s.item.node_b      = NODE_BITS'(b);
    s.item.edge_weight = EDGE_W_BITS'(w);
    edge_feed_q.insert(edge_feed_q.size(), s);
    queued_items++;
    run_budget += 64 + 8 * plan_nodes;
  endfunction

  function automatic void queue_drain();
    edge_feed_t s;
    s.drain = 1'b1;
    s.item  = '0;
    edge_feed_q.insert(edge_feed_q.size(), s);
  endfunction

  // Block until the sender is empty and every result is back; call at negedge.
  task automatic wait_drained();
    while (edge_feed_q.size() != 0 || pending_tree_results.size() != 0 || start)
      @(negedge clk);
  endtask

  // Write node_count while idle; the core then sweeps its parent memory.
  task automatic write_node_count(input int raw);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= NCNT_BITS'(raw);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reset_forest(raw);
    count_writes++;
    plan_nodes  = forest_nodes;
    run_budget += 8 * MAX_NODES;
    @(negedge clk);
  endtask

  // One random phase: mostly well-formed ascending edges, some noise.
  task automatic run_phase(input int raw, input int idle_pct);
    int n;
    int items;
    int chain_mode;
    int w;
    int r;
    int a;
    int b;
    write_node_count(raw);
    sender_idle_pct = idle_pct;
    n          = forest_nodes;
    items      = (n >= 200) ? 120 : 3 * n + 4;
    chain_mode = $urandom_range(1);
    w          = $urandom_range(65535 - items * 20);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      if (r < 6 && n < MAX_NODES) begin
        // Out-of-range endpoint on one side or both.
        if (r < 2) a = $urandom_range(MAX_NODES - 1, n);
        else if (r < 4) b = $urandom_range(MAX_NODES - 1, n);
        else begin
          a = $urandom_range(MAX_NODES - 1, n);
          b = $urandom_range(MAX_NODES - 1, n);
        end
        queue_edge(a, b, $urandom_range(65535));
      end else if (r < 10) begin
        queue_edge(a, a, w);
      end else begin
        if (r < 12) queue_drain();
        // Chain mode links k to k+1 so later finds walk long paths.
        if (chain_mode == 1 && k < n - 1) queue_edge(k, k + 1, w);
        else queue_edge(a, b, w);
        w = w + $urandom_range(20);
        if (w > 65535) w = 65535;
      end
    end
  endtask

  initial begin
    int phase;
    int raw;
    int idle_tbl [4];
    idle_tbl = '{0, 50, 0, 23};
    reset_forest(int'(NCNT_MAX));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, self loops, a five-node chain, then the special settings.
    queue_edge(0, MAX_NODES - 1, 0);
    queue_edge(MAX_NODES - 1, 0, 1);
    queue_edge(512, 512, 2);
    queue_edge(MAX_NODES - 1, MAX_NODES - 1, 3);
    queue_edge(682, 341, 65535);
    queue_edge(341, 682, 65535);
    queue_drain();
    for (int i = 1; i < 5; i++) queue_edge(i, i + 1, 65535);
    queue_edge(1, 5, 65535);
    queue_edge(1, 0, 65535);

    // Single node: complete from the start, everything ignored.
    write_node_count(0);
    queue_edge(0, 0, 5);
    queue_edge(0, 1, 5);

    // Value above the maximum clamps to the full forest.
    write_node_count(2047);
    queue_edge(MAX_NODES - 1, 0, 9);

    // Three nodes: out-of-range endpoints, self loop, completion.
    write_node_count(3);
    queue_edge(0, 1, 10);
    queue_edge(3, 0, 11);
    queue_edge(0, MAX_NODES - 1, 11);
    queue_edge(2, 2, 12);
    queue_edge(1, 2, 65535);
    queue_edge(0, 2, 65535);

    write_node_count(1025);
    queue_edge(MAX_NODES - 1, MAX_NODES - 2, 1);

    // Random phases until the queued edge total reaches the loop bound.
    phase = 0;
    while (queued_items < 1800) begin
      wait_drained();
      if (phase % 7 == 3) begin
        case ($urandom_range(2))
          0:       raw = MAX_NODES;
          1:       raw = 2047;
          default: raw = $urandom_range(MAX_NODES - 1, 200);
        endcase
      end else if (phase % 11 == 5) begin
        raw = 1;
      end else begin
        raw = $urandom_range(40, 2);
      end
      run_phase(raw, idle_tbl[phase % 4]);
      phase++;
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Run: %0d result beats checked, %0d edges reached the forest, %0d trees closed,",
             beats_checked, live_edges, trees_closed);
    $display("     %0d node-count writes over %0d random phases", count_writes, phase);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/kuf_pkg.sv
src/kruskal_union_find_edge_acceptor_core.sv
sim/tb_top.sv
